// ===== rtl/core/bijective_varint_codec_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bijective varint codec core
// Same-cycle and next-cycle implication checks on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef BIJECTIVE_VARINT_CODEC_CORE_DEFINES_SVH
`define BIJECTIVE_VARINT_CODEC_CORE_DEFINES_SVH

// pre holds -> post holds in the same cycle
`define BVC_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bvc: same-cycle check failed");

// pre holds -> post holds in the next cycle
`define BVC_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bvc: next-cycle check failed");

`endif

// ===== rtl/core/bvc_pkg.sv =====
// ---------------------------------------------------------------------------
// bvc_pkg
// Types, codes and lookup functions for the bijective varint codec.
// ---------------------------------------------------------------------------
package bvc_pkg;

    localparam int unsigned MAX_BYTES = 8;

    typedef logic [3:0]  len_t;
    typedef logic [63:0] word_t;

    typedef enum logic
    {
        KIND_ENCODE = 1'b0,
        KIND_DECODE = 1'b1
    } kind_t;

    localparam len_t MAX_LEN = len_t'(MAX_BYTES);

    // sum of 2^(8j-1) for j = 1 .. len-1
    function automatic word_t offset_sum(input len_t len);
        word_t s;
        begin
            case (len)
                4'd2:    s = 64'h0000_0000_0000_0080;
                4'd3:    s = 64'h0000_0000_0000_8080;
                4'd4:    s = 64'h0000_0000_0080_8080;
                4'd5:    s = 64'h0000_0000_8080_8080;
                4'd6:    s = 64'h0000_0080_8080_8080;
                4'd7:    s = 64'h0000_8080_8080_8080;
                4'd8:    s = 64'h0080_8080_8080_8080;
                default: s = '0;
            endcase
            return s;
        end
    endfunction

    function automatic word_t byte_mask(input len_t len);
        word_t m;
        begin
            case (len)
                4'd0:    m = 64'h0000_0000_0000_0000;
                4'd1:    m = 64'h0000_0000_0000_00ff;
                4'd2:    m = 64'h0000_0000_0000_ffff;
                4'd3:    m = 64'h0000_0000_00ff_ffff;
                4'd4:    m = 64'h0000_0000_ffff_ffff;
                4'd5:    m = 64'h0000_00ff_ffff_ffff;
                4'd6:    m = 64'h0000_ffff_ffff_ffff;
                4'd7:    m = 64'h00ff_ffff_ffff_ffff;
                default: m = '1;
            endcase
            return m;
        end
    endfunction

    // keep the low len bytes and sign-extend from the top kept byte
    function automatic word_t sign_ext(input len_t len, input word_t payload);
        word_t raw;
        logic  sgn;
        begin
            raw = payload & byte_mask(len);
            case (len)
                4'd1:    sgn = payload[7];
                4'd2:    sgn = payload[15];
                4'd3:    sgn = payload[23];
                4'd4:    sgn = payload[31];
                4'd5:    sgn = payload[39];
                4'd6:    sgn = payload[47];
                4'd7:    sgn = payload[55];
                default: sgn = 1'b0;
            endcase
            return sgn ? (raw | ~byte_mask(len)) : raw;
        end
    endfunction

endpackage

// ===== rtl/core/bijective_varint_codec_core.sv =====
// ---------------------------------------------------------------------------
// bijective_varint_codec_core
// Encodes a signed 64-bit integer to 0..8 bijective little-endian bytes, or
// decodes such bytes back, one word per clock when not stalled.
// ---------------------------------------------------------------------------
// Takes one input word per clock while in_stall is low and returns one result
// word per input, in order. An accepted word passes through the input
// register and then the result register, from which it is presented until
// the result handshake takes it.
// The path between the two is a bank of seven 64-bit constant compares that
// picks the encoded length, followed by one 64-bit adder shared by encode and
// decode; that adder path sets the clock. in_stall rises only when both
// registers hold words and out_stall is high.
`include "bijective_varint_codec_core_defines.svh"

module bijective_varint_codec_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic signed [63:0]  value_in,
    input  bvc_pkg::len_t       length_in,
    input  bvc_pkg::word_t      payload_in,
    output logic                out_valid,
    input  logic                out_stall,
    output bvc_pkg::len_t       length_out,
    output bvc_pkg::word_t      payload_out,
    output logic signed [63:0]  value_out,
    output logic                bad_length
);
    import bvc_pkg::*;

    // input stage
    logic               s1_valid_reg;
    logic               kind_reg;
    logic signed [63:0] value_reg;
    len_t               length_reg;
    word_t              payload_reg;

    // result stage
    logic               out_valid_reg;
    len_t               length_out_reg;
    word_t              payload_out_reg;
    logic signed [63:0] value_out_reg;
    logic               bad_length_reg;

    logic               s1_load;
    logic               s2_load;
    logic               s1_valid_next;
    logic               out_valid_next;

    logic               is_decode;
    logic [6:0]         enc_fits;
    len_t               enc_len;
    logic               enc_zero;
    len_t               sel_len;
    word_t              add_a;
    word_t              off_base;
    logic               flip;
    word_t              sum;

    len_t               length_out_next;
    word_t              payload_out_next;
    logic signed [63:0] value_out_next;
    logic               bad_length_next;

    assign s2_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign s1_load  = in_valid && !in_stall;

    always_comb
    begin
        if (s1_load)
            s1_valid_next = 1'b1;
        else if (s2_load)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s2_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // length k fits when the value lies within the cumulative offset C(k+1)
    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            logic signed [63:0] th;
            th = $signed(offset_sum(len_t'(i + 2)));
            if (!value_reg[63])
                enc_fits[i] = (value_reg <= th);
            else
                enc_fits[i] = (value_reg >= -th);
        end
    end

    always_comb
    begin
        enc_len = MAX_LEN;
        for (int i = 6; i >= 0; i--)
        begin
            if (enc_fits[i])
                enc_len = len_t'(i + 1);
        end
    end

    // encode:  v > 0 -> v - C - 1 = v + ~C ; v < 0 -> v + C
    // decode:  raw < 0 -> raw - C = raw + ~C + 1 ; else raw + C + 1
    assign is_decode = (kind_reg == KIND_DECODE);
    assign enc_zero  = (value_reg == '0);
    assign sel_len   = is_decode ? length_reg : enc_len;
    assign add_a     = is_decode ? sign_ext(length_reg, payload_reg) : word_t'(value_reg);
    assign off_base  = offset_sum(sel_len);
    assign flip      = is_decode ? add_a[63] : !add_a[63];
    assign sum       = add_a + (flip ? ~off_base : off_base) + word_t'(is_decode);

    always_comb
    begin
        length_out_next  = '0;
        payload_out_next = '0;
        value_out_next   = '0;
        bad_length_next  = 1'b0;
        if (is_decode)
        begin
            bad_length_next = (length_reg > MAX_LEN);
            if (!bad_length_next && length_reg != '0)
                value_out_next = $signed(sum);
        end
        else if (!enc_zero)
        begin
            length_out_next  = enc_len;
            payload_out_next = sum & byte_mask(enc_len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            kind_reg    <= kind;
            value_reg   <= value_in;
            length_reg  <= length_in;
            payload_reg <= payload_in;
        end
        if (s2_load)
        begin
            length_out_reg  <= length_out_next;
            payload_out_reg <= payload_out_next;
            value_out_reg   <= value_out_next;
            bad_length_reg  <= bad_length_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign length_out  = length_out_reg;
    assign payload_out = payload_out_reg;
    assign value_out   = value_out_reg;
    assign bad_length  = bad_length_reg;

    `BVC_ASSERT_NOW(a_bad_len_clean, out_valid && bad_length, value_out == '0 && length_out == '0)
    `BVC_ASSERT_NOW(a_len_range, out_valid_reg, length_out_reg <= MAX_LEN)
    `BVC_ASSERT_NOW(a_pay_unused_zero, out_valid, (payload_out & ~byte_mask(length_out)) == '0)
    `BVC_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, s1_valid_reg)

endmodule
